>>> hw/rtl/tpgm_pkg.sv
// Package for the target port group matcher: item, result and config types
// and the fixed codes shared by the parser and the top level.
// No dependencies.
package tpgm_pkg;

    // Configuration register indexes
    localparam logic CFG_REL_PORT_ID   = 1'b0;
    localparam logic CFG_PORT_GROUP_ID = 1'b1;

    // Path state codes of the result
    localparam logic [2:0] PATH_OPTIMIZED    = 3'd0;
    localparam logic [2:0] PATH_OTHER        = 3'd3;
    localparam logic [2:0] PATH_INACTIVE     = 3'd4;

    // Field masks
    localparam logic [7:0] STATE_NIBBLE_MASK = 8'h0f;

    // Widths of the packed stream words
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // One response byte as it enters the parser
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } item_t;

    // Match targets
    typedef struct packed {
        logic [15:0] rel_port_id;
        logic [15:0] port_group_id;
    } cfg_t;

    // One decision
    typedef struct packed {
        logic        matched;
        logic [2:0]  path_state;
        logic        preferred_path;
        logic [31:0] group_offset;
    } result_t;

endpackage

>>> hw/rtl/target_port_group_matcher_unit.sv
// Top level of the target port group matcher: config registers, input stage,
// parser and result register. Uses tpgm_pkg, tpgm_in_stage and tpgm_parser.
//
//  channel   direction  fields
//  s_*       in         tdata[7:0] data_byte, tuser first_byte
//  m_*       out        tdata[2:0] path_state, [3] preferred_path,
//                       [35:4] group_offset, [39:36] zero; tuser matched
//  cfg_*     in         index 0 rel_port_id, index 1 port_group_id
//
// One byte is taken per cycle unless stalled; a byte passes the input register
// and the parser, and a deciding byte puts its result in the output register
// as it leaves the input register. Throughput is set by the single parse state
// update per byte. Reset (aresetn low, synchronous) empties both registers and
// returns the parser to idle. A result held by m_tready low keeps the next
// byte in the input register, and s_tready drops once that register is full.
module target_port_group_matcher_unit
    import tpgm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] first_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] path_state, [3] preferred_path,
                                            // [35:4] group_offset, [39:36] zero
    output logic                 m_tuser    // [0] matched
);

    cfg_t    cfg_reg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_pop;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_REL_PORT_ID:   cfg_reg.rel_port_id   <= cfg_wdata;
                CFG_PORT_GROUP_ID: cfg_reg.port_group_id <= cfg_wdata;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign in_item.data_byte  = s_tdata;
    assign in_item.first_byte = s_tuser;

    tpgm_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    // Advance a byte when the result register is free or being drained
    assign item_pop = item_valid && (!out_valid_reg || m_tready);

    tpgm_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_pop),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_pop) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.matched;
    assign m_tdata  = {4'd0, out_reg.group_offset, out_reg.preferred_path,
                       out_reg.path_state};

endmodule

>>> hw/rtl/tpgm_in_stage.sv
// Input register stage of the target port group matcher.
// Holds one accepted transaction until the parser takes it. Uses tpgm_pkg.
module tpgm_in_stage
    import tpgm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_pop,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new transaction when empty or when the held one leaves
    assign in_ready   = !valid_reg || item_pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (item_pop) begin
            valid_reg <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hw/rtl/tpgm_parser.sv
// Byte-wise parser of a report-target-port-groups response.
// Updates its parse state once per byte and flags the deciding byte. Uses tpgm_pkg.
module tpgm_parser
    import tpgm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    // Parse phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DESC   = 2'd2;
    localparam logic [1:0] PH_PORT   = 2'd3;

    logic [1:0]  phase_reg,      phase_next;
    logic [32:0] pos_reg,        pos_next;
    logic [32:0] end_reg,        end_next;
    logic [2:0]  field_reg,      field_next;
    logic [3:0]  gstate_reg,     gstate_next;
    logic [15:0] gid_reg,        gid_next;
    logic [7:0]  ports_reg,      ports_next;
    logic [7:0]  hi_reg,         hi_next;
    logic [31:0] dstart_reg,     dstart_next;

    // Next-state and result logic for one byte
    always_comb begin
        logic [32:0] nxt;
        logic [15:0] rel;
        logic [7:0]  ports_dec;
        logic        at_boundary;
        logic        emit;
        logic [2:0]  st;

        nxt         = pos_reg + 33'd1;
        rel         = {hi_reg, item.data_byte};
        ports_dec   = ports_reg - 8'd1;
        at_boundary = 1'b0;
        emit        = 1'b0;
        st          = PATH_OTHER;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        field_next  = field_reg;
        gstate_next = gstate_reg;
        gid_next    = gid_reg;
        ports_next  = ports_reg;
        hi_next     = hi_reg;
        dstart_next = dstart_reg;

        res.matched        = 1'b0;
        res.path_state     = PATH_INACTIVE;
        res.preferred_path = 1'b0;
        res.group_offset   = 32'd0;

        // Restart on the first byte of a response
        if (item.first_byte) begin
            pos_next   = 33'd0;
            end_next   = 33'd0;
            phase_next = PH_HEADER;
            field_next = 3'd0;
            nxt        = 33'd1;
        end

        if (phase_next != PH_IDLE) begin
            pos_next = nxt;
            case (phase_next)
                PH_HEADER: begin
                    end_next = {1'b0, end_next[23:0], item.data_byte};
                    if (field_next >= 3'd3) begin
                        end_next    = end_next + 33'd4;
                        at_boundary = 1'b1;
                    end else begin
                        field_next = field_next + 3'd1;
                    end
                end
                PH_DESC: begin
                    if (field_next == 3'd0) begin
                        gstate_next = 4'(item.data_byte & STATE_NIBBLE_MASK);
                    end else if (field_next == 3'd2) begin
                        gid_next = {item.data_byte, 8'd0};
                    end else if (field_next == 3'd3) begin
                        gid_next = {gid_reg[15:8], item.data_byte};
                    end
                    if (field_next == 3'd7) begin
                        ports_next = item.data_byte;
                        if (item.data_byte == 8'd0) begin
                            at_boundary = 1'b1;
                        end else begin
                            phase_next = PH_PORT;
                            field_next = 3'd0;
                        end
                    end else begin
                        field_next = field_next + 3'd1;
                    end
                end
                PH_PORT: begin
                    if (field_next == 3'd2) begin
                        hi_next = item.data_byte;
                    end
                    if (field_next >= 3'd3) begin
                        if (rel == cfg.rel_port_id && gid_reg == cfg.port_group_id) begin
                            // Hit: report the group state of this descriptor
                            st                 = (gstate_reg <= 4'd2) ? gstate_reg[2:0]
                                                                      : PATH_OTHER;
                            emit               = 1'b1;
                            res.matched        = 1'b1;
                            res.path_state     = st;
                            res.preferred_path = (st == PATH_OPTIMIZED);
                            res.group_offset   = dstart_reg;
                        end else begin
                            ports_next = ports_dec;
                            if (ports_dec == 8'd0) begin
                                at_boundary = 1'b1;
                            end else begin
                                field_next = 3'd0;
                            end
                        end
                    end else begin
                        field_next = field_next + 3'd1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Descriptor boundary: finish without a match or open a descriptor
            if (at_boundary) begin
                if (nxt >= end_next) begin
                    emit = 1'b1;
                end else begin
                    phase_next  = PH_DESC;
                    field_next  = 3'd0;
                    dstart_next = nxt[31:0];
                end
            end

            if (emit) begin
                phase_next = PH_IDLE;
            end
        end

        res_valid = item_valid && emit;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 33'd0;
            end_reg   <= 33'd0;
            field_reg <= 3'd0;
            ports_reg <= 8'd0;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            end_reg   <= end_next;
            field_reg <= field_next;
            ports_reg <= ports_next;
        end
    end

    // Captured descriptor fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gstate_reg <= 4'd0;
            gid_reg    <= 16'd0;
            hi_reg     <= 8'd0;
            dstart_reg <= 32'd0;
        end else if (item_valid) begin
            gstate_reg <= gstate_next;
            gid_reg    <= gid_next;
            hi_reg     <= hi_next;
            dstart_reg <= dstart_next;
        end
    end

endmodule

>>> test/target_port_group_matcher_unit_tb.sv
// Testbench for target_port_group_matcher_unit: streams report-target-port-groups
// responses byte by byte and checks each decision against a built-in predictor.
// Depends on tpgm_pkg and the RTL of target_port_group_matcher_unit.
`timescale 1ns / 1ps

module target_port_group_matcher_unit_tb;
    import tpgm_pkg::*;

    // Walk of the response, as seen by the predictor
    localparam logic [1:0] WALK_IDLE   = 2'd0;
    localparam logic [1:0] WALK_LENGTH = 2'd1;
    localparam logic [1:0] WALK_GROUP  = 2'd2;
    localparam logic [1:0] WALK_ENTRY  = 2'd3;

    localparam int SETTLE_CYCLES = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_addr  = CFG_REL_PORT_ID;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Match targets as last written
    logic [15:0] target_rel = '0;
    logic [15:0] target_grp = '0;

    // Predictor state
    logic [1:0]  walk       = WALK_IDLE;
    logic [32:0] rsp_pos    = '0;
    logic [32:0] rsp_end    = '0;
    logic [2:0]  field_cnt  = '0;
    logic [3:0]  grp_state  = '0;
    logic [15:0] grp_id     = '0;
    logic [7:0]  ports_left = '0;
    logic [7:0]  rel_hi     = '0;
    logic [31:0] desc_off   = '0;
    logic        decided    = 1'b1;

    result_t     pending_decisions[$];
    logic [7:0]  rsp_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_bytes        = 0;
    int n_matches      = 0;
    int n_no_match     = 0;
    int n_checked      = 0;
    int errors         = 0;

    target_port_group_matcher_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Decision predictor
    // ---------------------------------------------------------------

    function automatic void close_walk(input result_t r);
        pending_decisions.push_back(r);
        walk    = WALK_IDLE;
        decided = 1'b1;
        if (r.matched) n_matches++;
        else n_no_match++;
    endfunction

    // Finish with no match or open the next group descriptor
    function automatic void at_boundary(input logic [32:0] nxt);
        result_t r;
        if (nxt >= rsp_end) begin
            r.matched        = 1'b0;
            r.path_state     = PATH_INACTIVE;
            r.preferred_path = 1'b0;
            r.group_offset   = '0;
            close_walk(r);
        end else begin
            walk      = WALK_GROUP;
            field_cnt = '0;
            desc_off  = nxt[31:0];
        end
    endfunction

    function automatic void predict_decision(input logic [7:0] b, input logic first);
        logic [32:0] nxt;
        logic [15:0] rel;
        result_t     r;
        if (first) begin
            rsp_pos   = '0;
            rsp_end   = '0;
            walk      = WALK_LENGTH;
            field_cnt = '0;
            decided   = 1'b0;
        end
        if (walk == WALK_IDLE || decided) return;

        nxt     = rsp_pos + 33'd1;
        rsp_pos = nxt;

        case (walk)
            WALK_LENGTH: begin
                rsp_end = {1'b0, rsp_end[23:0], b};
                if (field_cnt >= 3'd3) begin
                    rsp_end = rsp_end + 33'd4;
                    at_boundary(nxt);
                end else begin
                    field_cnt = field_cnt + 3'd1;
                end
            end
            WALK_GROUP: begin
                if (field_cnt == 3'd0) grp_state = 4'(b & STATE_NIBBLE_MASK);
                else if (field_cnt == 3'd2) grp_id = {b, 8'h00};
                else if (field_cnt == 3'd3) grp_id[7:0] = b;
                if (field_cnt >= 3'd7) begin
                    ports_left = b;
                    if (b == 8'd0) begin
                        at_boundary(nxt);
                    end else begin
                        walk      = WALK_ENTRY;
                        field_cnt = '0;
                    end
                end else begin
                    field_cnt = field_cnt + 3'd1;
                end
            end
            WALK_ENTRY: begin
                if (field_cnt == 3'd2) rel_hi = b;
                if (field_cnt >= 3'd3) begin
                    rel = {rel_hi, b};
                    if (rel == target_rel && grp_id == target_grp) begin
                        r.matched        = 1'b1;
                        r.path_state     = (grp_state <= 4'd2) ? grp_state[2:0] : PATH_OTHER;
                        r.preferred_path = (r.path_state == PATH_OPTIMIZED);
                        r.group_offset   = desc_off;
                        close_walk(r);
                    end else begin
                        ports_left = ports_left - 8'd1;
                        if (ports_left == 8'd0) at_boundary(nxt);
                        else field_cnt = '0;
                    end
                end else begin
                    field_cnt = field_cnt + 3'd1;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------

    always @(posedge aclk) begin : check_decisions
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decisions.size() == 0) begin
                errors++;
                $display("%0t: unexpected decision: tuser=%b tdata=%h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_decisions.pop_front();
                n_checked++;
                if (m_tuser !== want.matched || m_tdata[2:0] !== want.path_state
                        || m_tdata[3] !== want.preferred_path
                        || m_tdata[35:4] !== want.group_offset
                        || m_tdata[39:36] !== 4'd0) begin
                    errors++;
                    $display({"%0t: decision mismatch: expected ",
                              "matched=%b state=%0d pref=%b off=%h pad=0"},
                             $time, want.matched, want.path_state, want.preferred_path,
                             want.group_offset);
                    $display({"%0t:                   actual   ",
                              "matched=%b state=%0d pref=%b off=%h pad=%h"},
                             $time, m_tuser, m_tdata[2:0], m_tdata[3], m_tdata[35:4],
                             m_tdata[39:36]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Hand one byte to the block; valid stays high into the next call
    task automatic send_byte(input logic [7:0] b, input logic first);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_bytes++;
        predict_decision(b, first);
    endtask

    // Hold the input until every expected decision has left the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_targets(input logic [15:0] rel, input logic [15:0] grp);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_REL_PORT_ID;
        cfg_wdata <= rel;
        @(posedge aclk);
        target_rel = rel;
        cfg_addr  <= CFG_PORT_GROUP_ID;
        cfg_wdata <= grp;
        @(posedge aclk);
        target_grp = grp;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void put_desc(input logic [7:0] state_b, input logic [15:0] gid,
                                     input logic [7:0] count);
        rsp_bytes.push_back(state_b);
        rsp_bytes.push_back(8'($urandom));
        rsp_bytes.push_back(gid[15:8]);
        rsp_bytes.push_back(gid[7:0]);
        repeat (3) rsp_bytes.push_back(8'($urandom));
        rsp_bytes.push_back(count);
    endfunction

    function automatic void put_entry(input logic [15:0] rel);
        rsp_bytes.push_back(8'($urandom));
        rsp_bytes.push_back(8'($urandom));
        rsp_bytes.push_back(rel[15:8]);
        rsp_bytes.push_back(rel[7:0]);
    endfunction

    // Prepend the big-endian length field to the body built so far
    function automatic void put_length(input logic [31:0] len);
        rsp_bytes.push_front(len[7:0]);
        rsp_bytes.push_front(len[15:8]);
        rsp_bytes.push_front(len[23:16]);
        rsp_bytes.push_front(len[31:24]);
    endfunction

    task automatic send_response();
        foreach (rsp_bytes[i]) send_byte(rsp_bytes[i], i == 0);
        rsp_bytes.delete();
    endtask

    // Random response: mostly well-formed, some with bad length, cut short or padded
    task automatic send_random_response();
        int n_groups;
        int n_ports;
        int hit_g;
        int hit_p;
        int roll;
        logic [7:0]  state_b;
        logic [15:0] gid;
        logic [15:0] rel;
        logic [31:0] len;
        n_groups = $urandom_range(0, 3);
        hit_g = (n_groups > 0 && $urandom_range(0, 99) < 65)
                ? $urandom_range(0, n_groups - 1) : -1;
        for (int g = 0; g < n_groups; g++) begin
            n_ports = $urandom_range(0, 3);
            if (g == hit_g && n_ports == 0) n_ports = 1;
            hit_p = (g == hit_g) ? $urandom_range(0, n_ports - 1) : -1;
            state_b = ($urandom_range(0, 99) < 70) ? {4'($urandom), 4'($urandom_range(0, 3))}
                                                   : 8'($urandom);
            gid = (g == hit_g || $urandom_range(0, 99) < 15) ? target_grp : 16'($urandom);
            put_desc(state_b, gid, 8'(n_ports));
            for (int p = 0; p < n_ports; p++) begin
                rel = (p == hit_p || $urandom_range(0, 99) < 15) ? target_rel : 16'($urandom);
                put_entry(rel);
            end
        end

        roll = $urandom_range(0, 99);
        if (roll < 75) len = rsp_bytes.size();
        else if (roll < 83) len = rsp_bytes.size() + $urandom_range(1, 12);
        else if (roll < 91) len = $urandom_range(0, rsp_bytes.size());
        else if (roll < 95) len = $urandom;
        else len = '0;
        put_length(len);

        // Cut short or pad with bytes the block should ignore or keep walking
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            repeat ($urandom_range(1, rsp_bytes.size() - 1)) void'(rsp_bytes.pop_back());
        end else if (roll < 15) begin
            repeat ($urandom_range(1, 4)) rsp_bytes.push_back(8'($urandom));
        end
        send_response();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_directed();
        logic [7:0] states[4];
        states = '{8'h01, 8'hF2, 8'h03, 8'h0F};

        // Bytes before any response are ignored
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);

        // Zero length ends at once with no match
        put_length(32'd0);
        send_response();

        // Reset targets: port 0 in group 0, optimized
        put_desc(8'h00, 16'h0000, 8'd1);
        put_entry(16'h0000);
        put_length(32'd12);
        send_response();

        set_targets(16'hFFFF, 16'hFFFF);

        // Each group state behind an empty group
        foreach (states[i]) begin
            put_desc(8'h30, 16'h1234, 8'd0);
            put_desc(states[i], 16'hFFFF, 8'd1);
            put_entry(16'hFFFF);
            put_length(32'd20);
            send_response();
        end

        // Group matches but no port does
        put_desc(8'h00, 16'hFFFF, 8'd2);
        put_entry(16'hFFFE);
        put_entry(16'h7FFF);
        put_length(32'd16);
        send_response();

        // Port matches but group does not
        put_desc(8'h00, 16'hFFFE, 8'd1);
        put_entry(16'hFFFF);
        put_length(32'd12);
        send_response();

        // Restart mid-response, then trailing bytes after the answer
        put_desc(8'h00, 16'hFFFF, 8'd3);
        put_length(32'd20);
        repeat (rsp_bytes.size() - 6) void'(rsp_bytes.pop_back());
        send_response();
        put_desc(8'h02, 16'hFFFF, 8'd1);
        put_entry(16'hFFFF);
        put_length(32'd12);
        send_response();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // Entries of a descriptor begun before the end are still walked
        put_desc(8'h01, 16'hFFFF, 8'd2);
        put_entry(16'h0000);
        put_entry(16'hFFFF);
        put_length(32'd8);
        send_response();

        // Largest length field
        put_desc(8'h02, 16'hFFFF, 8'd1);
        put_entry(16'hFFFF);
        put_length(32'hFFFF_FFFF);
        send_response();

        // Largest port count, matching on the third entry
        put_desc(8'h00, 16'hFFFF, 8'hFF);
        put_entry(16'h0001);
        put_entry(16'h0002);
        put_entry(16'hFFFF);
        put_length(32'd16);
        send_response();

        wait_drained();
    endtask

    task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
        int stop_at;
        stop_at        = n_bytes + n_items;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n_bytes < stop_at) begin
            // Stray bytes between responses
            if ($urandom_range(0, 99) < 6) begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom), ($urandom_range(0, 99) < 20));
            end
            // Hold off until the block has answered everything
            if ($urandom_range(0, 99) < 4) wait_drained();
            send_random_response();
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();

        set_targets(16'($urandom), 16'($urandom));
        test_random_mix(325, 0, 0);
        set_targets(16'h0000, 16'hFFFF);
        test_random_mix(325, 45, 0);
        set_targets(16'hFFFF, 16'h0000);
        test_random_mix(325, 0, 45);
        set_targets(16'($urandom), 16'($urandom));
        test_random_mix(325, 14, 14);

        wait_drained();
        if (pending_decisions.size() != 0) begin
            errors++;
            $display("%0t: %0d decisions never arrived", $time, pending_decisions.size());
        end

        $display("Run covered %0d response bytes over directed cases and four handshake mixes,",
                 n_bytes);
        $display("with %0d decisions checked (%0d matches, %0d no-match) and %0d errors.",
                 n_checked, n_matches, n_no_match, errors);
        if (errors == 0) begin
            $display("target_port_group_matcher_unit verification clean");
        end else begin
            $display("target_port_group_matcher_unit verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d decisions still pending", $time, pending_decisions.size());
        $display("target_port_group_matcher_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tpgm_pkg.sv
hw/rtl/tpgm_in_stage.sv
hw/rtl/tpgm_parser.sv
hw/rtl/target_port_group_matcher_unit.sv
test/target_port_group_matcher_unit_tb.sv
